>>> hdl/ifhb_pkg.sv
// Shared types, constants and a helper function of the IPv4 fragment header builder.
package ifhb_pkg;

   // Header constants
   localparam logic [13:0] HDR_LEN     = 14'd20;
   localparam logic [15:0] VER_IHL_TOS = 16'h4500;
   localparam logic [7:0]  TTL_VALUE   = 8'h40;

   // MTU limits and reset value
   localparam logic [13:0] MTU_LOW   = 14'd1044;
   localparam logic [13:0] MTU_HIGH  = 14'd9000;
   localparam logic [13:0] MTU_RESET = 14'd1500;

   // Fragment limit default
   localparam int MAX_FRAGMENTS_DEFAULT = 64;

   // CSR port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_MTU       = 4'd1;

   // Request payload
   typedef struct packed {
      logic [15:0] payload_length;
      logic [31:0] dest_address;
      logic [7:0]  protocol_number;
      logic [15:0] packet_ident;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [13:0] total_length;
      logic [12:0] offset_units;
      logic        more_fragments;
      logic [15:0] header_checksum;
      logic [15:0] payload_start;
      logic        last_fragment;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_A,
      ST_PREP_B,
      ST_CALC,
      ST_SUM,
      ST_SEND
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic prep_a;
      logic prep_b;
      logic calc;
      logic sum;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_frag;
   } status_type;

   // End-around carry fold of a 19-bit sum down to 16 bits
   function automatic logic [15:0] fold16(input logic [18:0] x);
      logic [16:0] t;
      logic [15:0] r;
      t = {1'b0, x[15:0]} + {14'd0, x[18:16]};
      r = t[15:0] + {15'd0, t[16]};
      return r;
   endfunction

endpackage

>>> hdl/ifhb_ctrl.sv
// Sequencing state machine of the fragment header builder.
module ifhb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ifhb_pkg::status_type  status,
   output ifhb_pkg::cmd_type     cmd
);

   ifhb_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifhb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ifhb_pkg::ST_IDLE: begin
            if (req_valid) state_in = ifhb_pkg::ST_PREP_A;
         end
         ifhb_pkg::ST_PREP_A: state_in = ifhb_pkg::ST_PREP_B;
         ifhb_pkg::ST_PREP_B: state_in = ifhb_pkg::ST_CALC;
         ifhb_pkg::ST_CALC:   state_in = ifhb_pkg::ST_SUM;
         ifhb_pkg::ST_SUM:    state_in = ifhb_pkg::ST_SEND;
         ifhb_pkg::ST_SEND: begin
            if (rsp_ready) begin
               state_in = status.last_frag ? ifhb_pkg::ST_IDLE : ifhb_pkg::ST_CALC;
            end
         end
         default: state_in = ifhb_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ifhb_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ifhb_pkg::ST_PREP_A: cmd.prep_a = 1'b1;
         ifhb_pkg::ST_PREP_B: cmd.prep_b = 1'b1;
         ifhb_pkg::ST_CALC:   cmd.calc   = 1'b1;
         ifhb_pkg::ST_SUM:    cmd.sum    = 1'b1;
         ifhb_pkg::ST_SEND:   rsp_valid  = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> hdl/ifhb_dp.sv
// Datapath: config registers, fragment bookkeeping and header checksum.
module ifhb_dp #(
   parameter int MAX_FRAGMENTS = ifhb_pkg::MAX_FRAGMENTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ifhb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ifhb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  ifhb_pkg::req_type                   req_payload,
   input  ifhb_pkg::cmd_type                   cmd,
   output ifhb_pkg::status_type                status,
   output ifhb_pkg::rsp_type                   rsp_payload
);

   localparam int CNT_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAGMENTS - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [31:0]       src_ff;
   logic [13:0]       mtu_ff;
   ifhb_pkg::req_type req_ff;
   logic [17:0]       wordsum_ff;
   logic [13:0]       chunk_ff;
   logic [15:0]       base_ff;
   logic [15:0]       bytes_left_ff;
   logic [15:0]       next_start_ff;
   logic [CNT_W-1:0]  frag_cnt_ff;
   logic [13:0]       part_ff;
   logic              more_ff;
   logic              final_ff;
   ifhb_pkg::rsp_type rsp_ff;

   logic [13:0]       mtu_sat;
   logic [13:0]       chunk_in;
   logic [17:0]       wordsum_in;
   logic [18:0]       base_raw;
   logic              more_in;
   logic [13:0]       part_in;
   logic [13:0]       total_len;
   logic [15:0]       flag_off;
   logic [18:0]       cks_raw;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= '0;
         mtu_ff <= ifhb_pkg::MTU_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ifhb_pkg::CSR_SOURCE_ADDRESS: src_ff <= csr_wdata;
            ifhb_pkg::CSR_LINK_MTU:       mtu_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Chunk size from saturated MTU, rounded down to 8-byte units
   always_comb begin
      if (mtu_ff < ifhb_pkg::MTU_LOW)       mtu_sat = ifhb_pkg::MTU_LOW;
      else if (mtu_ff > ifhb_pkg::MTU_HIGH) mtu_sat = ifhb_pkg::MTU_HIGH;
      else                                  mtu_sat = mtu_ff;
      chunk_in = (mtu_sat - ifhb_pkg::HDR_LEN) & ~14'd7;
   end

   // Address words of the checksum
   assign wordsum_in = {2'd0, src_ff[31:16]} + {2'd0, src_ff[15:0]}
                     + {2'd0, req_ff.dest_address[31:16]}
                     + {2'd0, req_ff.dest_address[15:0]};

   // Remaining fixed header words
   assign base_raw = {1'b0, wordsum_ff} + {3'd0, ifhb_pkg::VER_IHL_TOS}
                   + {3'd0, ifhb_pkg::TTL_VALUE, req_ff.protocol_number}
                   + {3'd0, req_ff.packet_ident};

   // Fragment size and flags
   assign more_in   = bytes_left_ff > {2'd0, chunk_ff};
   assign part_in   = more_in ? chunk_ff : bytes_left_ff[13:0];
   assign total_len = ifhb_pkg::HDR_LEN + part_ff;
   assign flag_off  = {2'd0, more_ff, next_start_ff[15:3]};
   assign cks_raw   = {3'd0, base_ff} + {5'd0, total_len} + {3'd0, flag_off};

   // Request hold, per-request setup and per-fragment bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff        <= req_payload;
         bytes_left_ff <= req_payload.payload_length;
         next_start_ff <= '0;
         frag_cnt_ff   <= '0;
      end else if (cmd.sum) begin
         bytes_left_ff <= bytes_left_ff - {2'd0, part_ff};
         next_start_ff <= next_start_ff + {2'd0, part_ff};
         frag_cnt_ff   <= frag_cnt_ff + CNT_ONE;
      end
      if (cmd.prep_a) begin
         wordsum_ff <= wordsum_in;
         chunk_ff   <= chunk_in;
      end
      if (cmd.prep_b) begin
         base_ff <= ifhb_pkg::fold16(base_raw);
      end
      if (cmd.calc) begin
         part_ff  <= part_in;
         more_ff  <= more_in;
         final_ff <= !more_in || (frag_cnt_ff == CNT_LAST);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         rsp_ff.total_length    <= total_len;
         rsp_ff.offset_units    <= next_start_ff[15:3];
         rsp_ff.more_fragments  <= more_ff;
         rsp_ff.header_checksum <= ~ifhb_pkg::fold16(cks_raw);
         rsp_ff.payload_start   <= next_start_ff;
         rsp_ff.last_fragment   <= final_ff;
      end
   end

   assign rsp_payload      = rsp_ff;
   assign status.last_frag = rsp_ff.last_fragment;

endmodule

>>> hdl/ipv4_fragment_header_builder_unit.sv
// Top level of the IPv4 fragment header builder.
// One request yields between 1 and MAX_FRAGMENTS fragment header descriptions,
// in order, each a transfer on the rsp_ channel; the last one carries
// last_fragment. A request is accepted in ST_IDLE, set up in ST_PREP_A (chunk
// size and address words) and ST_PREP_B (fixed checksum words), and then each
// fragment passes ST_CALC (size select), ST_SUM (checksum add and fold) and
// ST_SEND (result transfer, which waits for rsp_ready). A new
// request is taken only once the last fragment of the previous one has
// transferred. Registers (source_address, link_mtu) are written on the csr_
// channel, which is always ready; write them only while the block is idle.
module ipv4_fragment_header_builder_unit #(
   parameter int MAX_FRAGMENTS = ifhb_pkg::MAX_FRAGMENTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ifhb_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ifhb_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ifhb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ifhb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ifhb_pkg::cmd_type    cmd;
   ifhb_pkg::status_type status;

   assign csr_ready = 1'b1;

   ifhb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ifhb_dp #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hdl/ifhb_checker.sv
// Port-level assertions for the fragment header builder, with bind.
module ifhb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ifhb_pkg::rsp_type rsp_payload
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // No new request while results are being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while emitting");

   // An accepted request closes the input for the next cycle
   a_req_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after request transfer");

   // A non-final fragment always has more-fragments set
   a_mf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_fragment |-> rsp_payload.more_fragments)
      else $error("non-final fragment without MF");

   // Offset matches payload start and length covers the header
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.offset_units == rsp_payload.payload_start[15:3])
                    && (rsp_payload.total_length >= ifhb_pkg::HDR_LEN))
      else $error("offset or length inconsistent");

endmodule

bind ipv4_fragment_header_builder_unit ifhb_checker u_ifhb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> tb/tb.sv
// Self-checking testbench for the IPv4 fragment header builder: directed table, random phases.
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_PER_PHASE = 55;
   localparam int N_PHASES       = 8;
   localparam int N_DIR          = 14;
   localparam int IDX_W          = ifhb_pkg::CSR_INDEX_W;
   localparam int DATA_W         = ifhb_pkg::CSR_DATA_W;
   localparam logic [IDX_W-1:0] CSR_SPARE_FIRST = ifhb_pkg::CSR_LINK_MTU + IDX_W'(1);
   localparam logic [IDX_W-1:0] CSR_SPARE_LAST  = '1;

   // One directed row; want is only used when typed is set
   typedef struct packed {
      ifhb_pkg::req_type req;
      logic              typed;
      ifhb_pkg::rsp_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ifhb_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ifhb_pkg::rsp_type rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   // Mirror of the block's registers
   logic [31:0] ip_source = '0;
   logic [13:0] mtu_setting = ifhb_pkg::MTU_RESET;

   ifhb_pkg::rsp_type pending_frags[$];
   int unsigned error_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;

   // Directed rows; only the two empty payloads carry results typed in by hand
   stim_row_type dir_table [N_DIR] = '{
      '{'{16'd0,     32'h0000_0000, 8'h00, 16'h0000}, 1'b1,
        '{14'd20, 13'd0, 1'b0, 16'h7AEB, 16'd0, 1'b1}},
      '{'{16'd0,     32'hFFFF_FFFF, 8'hFF, 16'hFFFF}, 1'b1,
        '{14'd20, 13'd0, 1'b0, 16'h79EC, 16'd0, 1'b1}},
      '{'{16'd1,     32'h0A00_0001, 8'd17, 16'h0001}, 1'b0, '0},
      '{'{16'd1480,  32'h0A00_0002, 8'd1,  16'h0002}, 1'b0, '0},
      '{'{16'd1481,  32'h0A00_0003, 8'd6,  16'h0003}, 1'b0, '0},
      '{'{16'd2960,  32'h0A00_0004, 8'd17, 16'h0004}, 1'b0, '0},
      '{'{16'd2961,  32'h0A00_0005, 8'd17, 16'h0005}, 1'b0, '0},
      '{'{16'd65515, 32'hC0A8_0001, 8'd17, 16'h1234}, 1'b0, '0},
      '{'{16'd65535, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF}, 1'b0, '0},
      '{'{16'd7,     32'h7F00_0001, 8'd1,  16'h8000}, 1'b0, '0},
      '{'{16'd8,     32'h0000_0001, 8'd6,  16'h7FFF}, 1'b0, '0},
      '{'{16'd1479,  32'hAC10_0001, 8'd17, 16'h0100}, 1'b0, '0},
      '{'{16'h8000,  32'h8000_0000, 8'h80, 16'hAAAA}, 1'b0, '0},
      '{'{16'h5555,  32'h5555_5555, 8'h55, 16'h5555}, 1'b0, '0}
   };

   ipv4_fragment_header_builder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fragment payload size for the current MTU, after saturation
   function automatic int unsigned chunk_bytes();
      int unsigned mtu;
      mtu = mtu_setting;
      if (mtu < ifhb_pkg::MTU_LOW) mtu = ifhb_pkg::MTU_LOW;
      if (mtu > ifhb_pkg::MTU_HIGH) mtu = ifhb_pkg::MTU_HIGH;
      return ((mtu - ifhb_pkg::HDR_LEN) / 8) * 8;
   endfunction

   // One's-complement header checksum with the checksum word as zero
   function automatic logic [15:0] ip_checksum(logic [13:0] total, logic [15:0] flag_off,
                                               ifhb_pkg::req_type r);
      logic [31:0] acc;
      acc = 32'(ifhb_pkg::VER_IHL_TOS) + 32'(total) + 32'(r.packet_ident) + 32'(flag_off)
          + 32'({ifhb_pkg::TTL_VALUE, r.protocol_number})
          + 32'(ip_source[31:16]) + 32'(ip_source[15:0])
          + 32'(r.dest_address[31:16]) + 32'(r.dest_address[15:0]);
      while (acc[31:16] != 0)
         acc = 32'(acc[15:0]) + 32'(acc[31:16]);
      return ~acc[15:0];
   endfunction

   // Queue up every fragment header the request should produce
   function automatic void predict_fragments(ifhb_pkg::req_type r);
      int unsigned       chunk, left, start, part, n;
      logic              more;
      ifhb_pkg::rsp_type f;
      chunk = chunk_bytes();
      left  = r.payload_length;
      start = 0;
      n     = 0;
      do begin
         more  = left > chunk;
         part  = more ? chunk : left;
         n++;
         f.total_length    = 14'(ifhb_pkg::HDR_LEN + part);
         f.offset_units    = 13'(start >> 3);
         f.more_fragments  = more;
         f.header_checksum = ip_checksum(f.total_length, {2'b00, more, f.offset_units}, r);
         f.payload_start   = 16'(start);
         f.last_fragment   = !more || (n >= ifhb_pkg::MAX_FRAGMENTS_DEFAULT);
         pending_frags.push_back(f);
         left  -= part;
         start += part;
      end while (!f.last_fragment);
   endfunction

   // Random request; lengths lean toward small sizes and chunk boundaries
   function automatic ifhb_pkg::req_type random_request();
      ifhb_pkg::req_type r;
      int unsigned       chunk, k, len;
      chunk = chunk_bytes();
      case ($urandom_range(0, 3))
         0: len = $urandom_range(0, 3000);
         1: begin
            k   = $urandom_range(1, 65535 / chunk);
            len = k * chunk + $urandom_range(0, 2) - 1;
            if (len > 65535) len = 65535;
         end
         default: len = $urandom_range(0, 65535);
      endcase
      r.payload_length  = 16'(len);
      r.dest_address    = $urandom;
      r.protocol_number = 8'($urandom_range(0, 255));
      r.packet_ident    = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Register write; csr_valid is left high for a following write
   task automatic write_csr(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == ifhb_pkg::CSR_SOURCE_ADDRESS)
         ip_source = data;
      else if (idx == ifhb_pkg::CSR_LINK_MTU)
         mtu_setting = data[13:0];
   endtask

   // Request transfer with random sender gaps; req_valid stays high afterwards
   task automatic send_request(ifhb_pkg::req_type r, logic typed, ifhb_pkg::rsp_type want);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (typed)
         pending_frags.push_back(want);
      else
         predict_fragments(r);
   endtask

   // Hold off the sender until every expected fragment is back
   task automatic drain_fragments();
      req_valid <= 1'b0;
      while (pending_frags.size() != 0) @(posedge clock);
   endtask

   // Result checking and receiver back-pressure
   always @(posedge clock) begin
      ifhb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frags.size() == 0) begin
            $display("%0t: unexpected fragment, expected none, actual %h", $time, rsp_payload);
            error_count++;
         end else begin
            want = pending_frags.pop_front();
            check_field("total_length", want.total_length, rsp_payload.total_length);
            check_field("offset_units", want.offset_units, rsp_payload.offset_units);
            check_field("more_fragments", want.more_fragments, rsp_payload.more_fragments);
            check_field("header_checksum", want.header_checksum, rsp_payload.header_checksum);
            check_field("payload_start", want.payload_start, rsp_payload.payload_start);
            check_field("last_fragment", want.last_fragment, rsp_payload.last_fragment);
         end
      end
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= $urandom_range(0, 99) >= stall_pct;
   end

   // Watchdog: cycles without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d fragments outstanding", $time,
                  pending_frags.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      ifhb_pkg::req_type r;
      logic [31:0]       src_word, mtu_word;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Unused register index must leave reset values alone
      write_csr(CSR_SPARE_LAST, '1);
      csr_valid <= 1'b0;

      // Directed rows at reset configuration
      foreach (dir_table[i])
         send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

      // Random phases, each with its own register setting and pacing
      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain_fragments();
         src_word = $urandom;
         case (ph)
            0: begin
               mtu_word = {18'($urandom), ifhb_pkg::MTU_LOW};
               gap_pct = 0;  stall_pct = 0;
            end
            1: begin
               src_word = '1; mtu_word = {18'd0, ifhb_pkg::MTU_HIGH};
               gap_pct = 66; stall_pct = 0;
            end
            2: begin
               mtu_word = {18'($urandom), 14'd0};
               gap_pct = 0;  stall_pct = 66;
            end
            3: begin
               mtu_word = '1;
               gap_pct = 32; stall_pct = 32;
            end
            4: begin
               src_word = '0;
               mtu_word = {18'($urandom), ifhb_pkg::MTU_LOW - 14'd1};
               gap_pct = 0;  stall_pct = 0;
            end
            5: begin
               mtu_word = {18'd0, ifhb_pkg::MTU_HIGH + 14'd1};
               gap_pct = 66; stall_pct = 0;
            end
            6: begin
               mtu_word = {18'($urandom),
                           14'($urandom_range(ifhb_pkg::MTU_LOW, ifhb_pkg::MTU_HIGH))};
               gap_pct = 0;  stall_pct = 66;
            end
            default: begin
               mtu_word = $urandom;
               gap_pct = 32; stall_pct = 32;
            end
         endcase
         write_csr(IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), $urandom);
         write_csr(ifhb_pkg::CSR_SOURCE_ADDRESS, src_word);
         write_csr(ifhb_pkg::CSR_LINK_MTU, mtu_word);
         csr_valid <= 1'b0;

         // Longest packet, then an exact multiple of the chunk
         r = random_request();
         r.payload_length = '1;
         send_request(r, 1'b0, '0);
         r = random_request();
         r.payload_length = 16'($urandom_range(1, 65535 / chunk_bytes()) * chunk_bytes());
         send_request(r, 1'b0, '0);

         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_request(random_request(), 1'b0, '0);
      end

      drain_fragments();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
